// ----- hdl/encoder_frame_crc32_position_decoder_assert.svh -----
// Assertion macros shared by the encoder frame decoder modules.
// No dependencies; included by files that carry concurrent checks.
`ifndef ENCODER_FRAME_CRC32_POSITION_DECODER_ASSERT_SVH
`define ENCODER_FRAME_CRC32_POSITION_DECODER_ASSERT_SVH
`ifndef SYNTH
`define ECPD_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("ecpd assertion failed");
`define ECPD_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("ecpd assertion failed");
`else
`define ECPD_ASSERT(lbl, clk_s, rst_s, prop)
`define ECPD_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif
`endif

// ----- hdl/ecpd_pkg.sv -----
// Types, constants and the CRC-32 byte update for the encoder frame decoder.
// No dependencies.
package ecpd_pkg;

  localparam logic [4:0]  FrameLen      = 5'd21;
  localparam logic [4:0]  LastIdx       = 5'd20;
  localparam logic [4:0]  CrcLen        = 5'd17;
  localparam logic [31:0] CrcPoly       = 32'hEDB88320;
  localparam logic [7:0]  DeviceIdReset = 8'd1;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_ID_MISMATCH  = 2'd1,
    STATUS_CRC_MISMATCH = 2'd2
  } ecpd_status_t;

  // One classified byte on its way from the front to the back.
  typedef struct packed {
    logic [7:0] data;
    logic [4:0] idx;
  } ecpd_entry_t;

  // Reflected CRC-32 update of the raw register by one byte.
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

endpackage

// ----- hdl/ecpd_if.sv -----
// Valid/ready channel interfaces for the encoder frame decoder.
// No dependencies.
interface ecpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface ecpd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         frame_status;
  logic [19:0]        single_turn_position;
  logic signed [39:0] raw_position;

  modport source (output valid, output frame_status, output single_turn_position,
                  output raw_position, input ready);
  modport sink   (input valid, input frame_status, input single_turn_position,
                  input raw_position, output ready);
endinterface

// ----- hdl/encoder_frame_crc32_position_decoder.sv -----
// Top level of the CRC-32 checked absolute encoder frame decoder.
// Depends on ecpd_pkg, ecpd_if, ecpd_front, ecpd_queue and ecpd_back.
//
// Decodes 21-byte encoder replies fed one word (byte) per handshake on in_ch.
// Byte 0 is checked against device_id, bytes 1 to 5 give a big-endian signed
// 40-bit position, bytes 0 to 16 are covered by a reflected CRC-32 that is
// compared with little-endian bytes 17 to 20. One result word leaves on out_ch
// after byte 20: status 0 ok, 1 id mismatch, 2 CRC mismatch, with the last
// good position (raw and modulo 2^TURN_BITS). A byte is taken every cycle;
// the result is registered: byte 20 passes through the two-entry queue
// between the byte classifier and the checking back part, which loads the
// result register as it pops the byte. Input stalls only when that queue is
// full, i.e. when a finished result waits unclaimed. The user must write
// device_id through cfg_wr_en/cfg_wr_data only while the block is idle;
// the block itself does not enforce this.
module encoder_frame_crc32_position_decoder #(
  parameter int TURN_BITS = 20
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  ecpd_in_if.sink    in_ch,
  ecpd_out_if.source out_ch
);
  import ecpd_pkg::*;

  logic        q_full;
  logic        q_push;
  ecpd_entry_t q_entry;
  logic        q_pop;
  logic        q_valid;
  ecpd_entry_t q_head;

  // Classify incoming words
  ecpd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  // Decouple front and back
  ecpd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // Check frames and produce results
  ecpd_back #(
    .TURN_BITS (TURN_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

endmodule

// ----- hdl/ecpd_front.sv -----
// Front part: accepts received words, tracks the byte index, classifies.
// Depends on ecpd_pkg and ecpd_in_if.
module ecpd_front (
  input  logic                 clk,
  input  logic                 rst,
  ecpd_in_if.sink              in_ch,
  input  logic                 q_full,
  output logic                 q_push,
  output ecpd_pkg::ecpd_entry_t q_entry
);
  import ecpd_pkg::*;

  logic [4:0] byte_counter;
  logic [4:0] idx;
  logic       accept;

  // Pick the index of this word; frame start forces byte zero
  assign idx          = in_ch.frame_start ? 5'd0 : byte_counter;
  assign in_ch.ready  = !q_full;
  assign accept       = in_ch.valid && in_ch.ready;
  assign q_push       = accept && (idx < FrameLen);
  assign q_entry.data = in_ch.rx_byte;
  assign q_entry.idx  = idx;

  // Advance the counter; hold it at frame length past the end
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_counter <= 5'd0;
    end else if (accept) begin
      if (idx < FrameLen) begin
        byte_counter <= idx + 5'd1;
      end else begin
        byte_counter <= FrameLen;
      end
    end
  end

endmodule

// ----- hdl/ecpd_queue.sv -----
// Two-entry queue that decouples the front and back parts.
// Depends on ecpd_pkg and the assertion macro header.
`include "encoder_frame_crc32_position_decoder_assert.svh"
module ecpd_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  ecpd_pkg::ecpd_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output ecpd_pkg::ecpd_entry_t head
);
  import ecpd_pkg::*;

  ecpd_entry_t mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = mem[rd_ptr];

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  `ECPD_ASSERT(a_count_bound, clk, rst, count != 2'd3)
  `ECPD_ASSERT(a_no_push_full, clk, rst, !(push && full))
  `ECPD_ASSERT(a_no_pop_empty, clk, rst, pop |-> head_valid)

endmodule

// ----- hdl/ecpd_back.sv -----
// Back part: CRC, position assembly, frame checks and the result register.
// Depends on ecpd_pkg, ecpd_out_if and the assertion macro header.
`include "encoder_frame_crc32_position_decoder_assert.svh"
module ecpd_back #(
  parameter int TURN_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [7:0]            cfg_wr_data,
  input  logic                  q_valid,
  input  ecpd_pkg::ecpd_entry_t q_head,
  output logic                  q_pop,
  ecpd_out_if.source            out_ch
);
  import ecpd_pkg::*;

  localparam logic [39:0] TurnMask40 = (40'd1 << TURN_BITS) - 40'd1;
  localparam logic [19:0] TurnMask   = TurnMask40[19:0];

  logic [7:0]   device_id;
  logic [7:0]   id_seen;
  logic [31:0]  crc;
  logic [39:0]  pos;
  logic [31:0]  check;
  logic [39:0]  last_good;
  logic         out_valid;
  ecpd_status_t status;
  logic [19:0]  turn_pos;
  logic [39:0]  raw_pos;

  logic         is_last;
  logic [7:0]   id_next;
  logic [31:0]  crc_base;
  logic [31:0]  crc_next;
  logic [39:0]  pos_next;
  logic [31:0]  check_base;
  logic [31:0]  check_next;
  logic [4:0]   byte_ofs;
  ecpd_status_t status_next;
  logic [39:0]  good_next;
  logic         ok_done;

  // Take a word unless it finishes a frame and the result slot is busy
  assign is_last = (q_head.idx == LastIdx);
  assign q_pop   = q_valid && (!is_last || !out_valid || out_ch.ready);

  // Update frame state for the head word
  always_comb begin
    id_next    = (q_head.idx == 5'd0) ? q_head.data : id_seen;
    crc_base   = (q_head.idx == 5'd0) ? 32'hFFFFFFFF : crc;
    crc_next   = (q_head.idx < CrcLen) ? crc_byte(crc_base, q_head.data) : crc;
    pos_next   = (q_head.idx == 5'd0) ? 40'd0 : pos;
    if (q_head.idx inside {[5'd1:5'd5]}) begin
      pos_next = {pos[31:0], q_head.data};
    end
    byte_ofs   = q_head.idx - CrcLen;
    check_base = (q_head.idx == 5'd0) ? 32'd0 : check;
    check_next = check_base;
    if (q_head.idx >= CrcLen) begin
      check_next = check_base | ({24'h0, q_head.data} << {byte_ofs[1:0], 3'b000});
    end
  end

  // Judge the frame: id first, then the check word
  always_comb begin
    good_next = last_good;
    if (id_seen != device_id) begin
      status_next = STATUS_ID_MISMATCH;
    end else if (check_next != ~crc) begin
      status_next = STATUS_CRC_MISMATCH;
    end else begin
      status_next = STATUS_OK;
      good_next   = pos;
    end
  end

  assign ok_done = q_pop && is_last && (status_next == STATUS_OK);

  // Hold frame state, configuration and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      device_id <= DeviceIdReset;
      id_seen   <= 8'd0;
      crc       <= 32'hFFFFFFFF;
      pos       <= 40'd0;
      check     <= 32'd0;
      last_good <= 40'd0;
      out_valid <= 1'b0;
      status    <= STATUS_OK;
      turn_pos  <= 20'd0;
      raw_pos   <= 40'd0;
    end else begin
      if (cfg_wr_en) begin
        device_id <= cfg_wr_data;
      end
      if (q_pop) begin
        id_seen <= id_next;
        crc     <= crc_next;
        pos     <= pos_next;
        check   <= check_next;
      end
      if (q_pop && is_last) begin
        last_good <= good_next;
        out_valid <= 1'b1;
        status    <= status_next;
        turn_pos  <= good_next[19:0] & TurnMask;
        raw_pos   <= good_next;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_ch.valid                = out_valid;
  assign out_ch.frame_status         = status;
  assign out_ch.single_turn_position = turn_pos;
  assign out_ch.raw_position         = raw_pos;

  `ECPD_ASSERT(a_result_from_last, clk, rst, $rose(out_valid) |-> $past(q_pop && is_last))
  `ECPD_ASSERT(a_ok_matches_pos, clk, rst, ok_done |=> (raw_pos == $past(pos)))

endmodule
